@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file pmsb_checker.sv.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pmsb_pkg.sv @@
// Types and constants of the polyline miter strip builder.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pmsb_pkg;
	localparam int AXES       = 3;
	localparam int UNIT_SHIFT = 30;
	localparam int THICK_SHIFT = 8;
	localparam int QDEPTH     = 2;
	localparam int PTR_W      = $clog2(QDEPTH);
	localparam int CNT_W      = $clog2(QDEPTH + 1);
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam logic [1:0]  LAST_AXIS = 2'(AXES - 1);
	localparam logic [31:0] VB_STEP   = 32'd2;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        th;
		logic               last;
		logic               held;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} fb_link_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic [31:0]        path;
		logic [31:0]        vbase;
		logic               joins;
		logic               run_last;
	} rec_t;
endpackage
`default_nettype wire

@@ rtl/polyline_miter_strip_builder.sv @@
// Polyline miter strip builder top level: pmsb_front feeds pmsb_back via a 2-entry queue.
// A point that only gets held skips the arithmetic; a point that closes a record after a
// held point goes through the bit-serial square root and divider: three quotients for the
// unit direction and three more per record, and a point may close two records. The back
// end works one item at a time and takes no new item until it is through with the last.
// arst_n low clears both queues, the line state and the vertex counter.
`default_nettype none
module polyline_miter_strip_builder import pmsb_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [15:0] thickness,
	input  wire logic        line_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      vert_x,
	output logic [31:0]      vert_y,
	output logic [31:0]      vert_z,
	output logic [31:0]      offset_x,
	output logic [31:0]      offset_y,
	output logic [31:0]      offset_z,
	output logic [31:0]      path_length,
	output logic [31:0]      vertex_base,
	output logic             joins_previous,
	output logic             run_last
);
	localparam int EFF_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

	fb_link_t link;
	logic     take;
	rec_t     head;

	pmsb_front #(.EFF_BITS(EFF_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.thickness (thickness),
		.line_end  (line_end),
		.link      (link),
		.take      (take)
	);

	pmsb_back #(.EFF_BITS(EFF_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.take   (take),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	assign vert_x         = head.vx;
	assign vert_y         = head.vy;
	assign vert_z         = head.vz;
	assign offset_x       = head.ox;
	assign offset_y       = head.oy;
	assign offset_z       = head.oz;
	assign path_length    = head.path;
	assign vertex_base    = head.vbase;
	assign joins_previous = head.joins;
	assign run_last       = head.run_last;
endmodule
`default_nettype wire

@@ rtl/pmsb_front.sv @@
// Front end: accepts points, sign extends them, classifies them against
// the held-point flag and queues them for the back end. Uses pmsb_pkg.
`default_nettype none
module pmsb_front import pmsb_pkg::*; #(
	parameter int EFF_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [15:0] thickness,
	input  wire logic        line_end,
	output fb_link_t         link,
	input  wire logic        take
);
	item_t             fifo_q [QDEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              have_held_q;
	logic              acc, deq;
	item_t             item_c;

	assign full = (count_q == CNT_W'(QDEPTH));
	assign acc  = push && !full;
	assign deq  = take && (count_q != '0);

	always_comb begin
		item_c.x    = 32'($signed(pos_x[EFF_BITS-1:0]));
		item_c.y    = 32'($signed(pos_y[EFF_BITS-1:0]));
		item_c.z    = 32'($signed(pos_z[EFF_BITS-1:0]));
		item_c.th   = thickness;
		item_c.last = line_end;
		item_c.held = have_held_q;
	end

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= item_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			count_q     <= '0;
			have_held_q <= 1'b0;
		end else begin
			if (acc) begin
				wr_q        <= wr_q + 1'b1;
				have_held_q <= !line_end;
			end
			if (deq) rd_q <= rd_q + 1'b1;
			unique case ({acc, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign link.valid = (count_q != '0);
	assign link.item  = fifo_q[rd_q];
endmodule
`default_nettype wire

@@ rtl/pmsb_sqrt.sv @@
// Bit-serial floor square root, two radicand bits per cycle.
// Uses pmsb_pkg for the step count.
`default_nettype none
module pmsb_sqrt import pmsb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	localparam int SC_W = $clog2(SQRT_STEPS);

	logic [63:0]     val_q;
	logic [33:0]     rem_q;
	logic [31:0]     root_q;
	logic [SC_W-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [35:0]     rem_sh, trial, rem_nx;
	logic            ge;

	always_comb begin
		rem_sh = {rem_q, val_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[61:0], 2'b00};
			rem_q  <= rem_nx[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SC_W'(SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ rtl/pmsb_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle (64 by 32 bits).
// Uses pmsb_pkg for the step count.
`default_nettype none
module pmsb_div import pmsb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [63:0]      quot
);
	localparam int DC_W = $clog2(DIV_STEPS);

	logic [31:0]     rem_q, den_q;
	logic [63:0]     quo_q;
	logic [DC_W-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [32:0]     trial, diff;
	logic            ge;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DC_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

@@ rtl/pmsb_back.sv @@
// Back end: sequencer that turns queued points into vertex-pair records,
// with shared multiplier, pmsb_sqrt, pmsb_div and the result queue. Uses pmsb_pkg.
`default_nettype none
module pmsb_back import pmsb_pkg::*; #(
	parameter int EFF_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire fb_link_t link,
	output logic          take,
	input  wire logic     pop,
	output logic          empty,
	output rec_t          head
);
	localparam logic [63:0] OFF_MAX = (64'd1 << (EFF_BITS - 1)) - 64'd1;

	typedef enum logic [4:0] {
		S_IDLE, S_CLASS, S_DIFF, S_SCALE, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO,
		S_SQRT_WAIT, S_UDIV_GO, S_UDIV_WAIT, S_TAN, S_DOT_MUL, S_DOT_ACC,
		S_DQ, S_NUM_MUL, S_NUM_GO, S_NUM_WAIT, S_REC, S_OUT
	} state_t;

	state_t             state_q;
	item_t              item_q;
	logic               first_rec_q;
	logic [1:0]         idx_q;
	logic [32:0]        mag_q [AXES];
	logic               neg_q [AXES];
	logic [30:0]        q_q [AXES];
	logic [1:0]         s_q;
	logic signed [63:0] acc_q, prod_q;
	logic [31:0]        l_q;
	logic signed [31:0] u_q [AXES];
	logic signed [31:0] ul_q [AXES];
	logic signed [31:0] t_q [AXES];
	logic signed [31:0] r_q [AXES];
	logic signed [31:0] off_q [AXES];
	logic [31:0]        dqm_q;
	logic               dqneg_q, numneg_q;
	logic signed [31:0] held_q [AXES];
	logic [15:0]        held_th_q;
	logic               held_first_q;
	logic [31:0]        run_len_q;
	logic [31:0]        vcount_q;
	rec_t               out_rec_q;

	logic signed [31:0] pt_c [AXES];
	logic signed [32:0] d_c [AXES];
	logic [32:0]        mag_c [AXES];
	logic [1:0]         s_c;
	logic signed [32:0] tsum_c [AXES];
	logic [32:0]        tadj_c [AXES];
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic [15:0]        th_sel;
	logic [63:0]        dot_abs, num_c, num_abs, sat64;
	logic [31:0]        sat32, off_pos;
	logic [33:0]        len_c;
	logic [34:0]        rsum_c;
	logic [31:0]        run_len_nx;
	logic               sq_done, dv_done, dv_start;
	logic [31:0]        sq_root;
	logic [63:0]        dv_quot, dv_num;
	logic [31:0]        dv_den;

	rec_t               ofifo_q [QDEPTH];
	logic [PTR_W-1:0]   owr_q, ord_q;
	logic [CNT_W-1:0]   ocount_q;
	logic               ofull, opush, opop;

	always_comb begin
		pt_c[0] = item_q.x;
		pt_c[1] = item_q.y;
		pt_c[2] = item_q.z;
		for (int i = 0; i < AXES; i++) begin
			d_c[i]    = 33'(pt_c[i]) - 33'(held_q[i]);
			mag_c[i]  = d_c[i][32] ? 33'(-d_c[i]) : 33'(d_c[i]);
			tsum_c[i] = 33'(u_q[i]) + 33'(ul_q[i]);
			tadj_c[i] = tsum_c[i] + {32'd0, tsum_c[i][32]};
		end
		if (mag_q[0][32] || mag_q[1][32] || mag_q[2][32])
			s_c = 2'd2;
		else if (mag_q[0][31] || mag_q[1][31] || mag_q[2][31])
			s_c = 2'd1;
		else
			s_c = 2'd0;
	end

	assign th_sel = first_rec_q ? held_th_q : item_q.th;

	always_comb begin
		mul_a = t_q[idx_q];
		mul_b = r_q[idx_q];
		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = $signed({1'b0, q_q[idx_q]});
				mul_b = $signed({1'b0, q_q[idx_q]});
			end
			S_NUM_MUL: begin
				mul_b = $signed({16'd0, th_sel});
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		dot_abs = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		num_c   = 64'(prod_q <<< THICK_SHIFT);
		num_abs = num_c[63] ? (64'd0 - num_c) : num_c;
		sat64   = (dv_quot > OFF_MAX) ? OFF_MAX : dv_quot;
		sat32   = sat64[31:0];
		off_pos = OFF_MAX[31:0];
		len_c   = 34'(l_q) << s_q;
		rsum_c  = {3'd0, run_len_q} + {1'b0, len_c};
		run_len_nx = (rsum_c[34:32] != 3'd0) ? 32'hFFFF_FFFF : rsum_c[31:0];
	end

	assign take     = (state_q == S_IDLE) && link.valid;
	assign dv_start = ((state_q == S_UDIV_GO) && (l_q != '0)) ||
	                  ((state_q == S_NUM_GO) && (dqm_q != '0));
	assign dv_num   = (state_q == S_UDIV_GO) ? (64'(q_q[idx_q]) << UNIT_SHIFT) : num_abs;
	assign dv_den   = (state_q == S_UDIV_GO) ? l_q : dqm_q;

	pmsb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQRT_GO),
		.radicand (64'(acc_q)),
		.done     (sq_done),
		.root     (sq_root)
	);

	pmsb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_rec_q  <= 1'b1;
			idx_q        <= '0;
			held_first_q <= 1'b1;
			run_len_q    <= '0;
			vcount_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (link.valid) begin
						item_q  <= link.item;
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (!item_q.held && item_q.last) begin
						out_rec_q.vx       <= pt_c[0];
						out_rec_q.vy       <= pt_c[1];
						out_rec_q.vz       <= pt_c[2];
						out_rec_q.ox       <= '0;
						out_rec_q.oy       <= '0;
						out_rec_q.oz       <= '0;
						out_rec_q.path     <= run_len_q;
						out_rec_q.vbase    <= vcount_q;
						out_rec_q.joins    <= 1'b0;
						out_rec_q.run_last <= 1'b1;
						state_q            <= S_OUT;
					end else if (!item_q.held) begin
						held_q       <= pt_c;
						held_th_q    <= item_q.th;
						held_first_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						first_rec_q <= 1'b1;
						state_q     <= S_DIFF;
					end
				end
				S_DIFF: begin
					for (int i = 0; i < AXES; i++) begin
						mag_q[i] <= mag_c[i];
						neg_q[i] <= d_c[i][32];
					end
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					s_q <= s_c;
					for (int i = 0; i < AXES; i++) q_q[i] <= 31'(mag_q[i] >> s_c);
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_SQ_MUL;
				end
				S_SQ_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					acc_q <= acc_q + prod_q;
					if (idx_q == LAST_AXIS) begin
						state_q <= S_SQRT_GO;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQRT_GO: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (sq_done) begin
						l_q     <= sq_root;
						idx_q   <= '0;
						state_q <= S_UDIV_GO;
					end
				end
				S_UDIV_GO: begin
					if (l_q == '0) begin
						u_q[idx_q] <= '0;
						if (idx_q == LAST_AXIS) begin
							state_q <= S_TAN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						state_q <= S_UDIV_WAIT;
					end
				end
				S_UDIV_WAIT: begin
					if (dv_done) begin
						u_q[idx_q] <= neg_q[idx_q] ? -$signed(dv_quot[31:0]) :
						                             $signed(dv_quot[31:0]);
						if (idx_q == LAST_AXIS) begin
							state_q <= S_TAN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_UDIV_GO;
						end
					end
				end
				S_TAN: begin
					for (int i = 0; i < AXES; i++) begin
						if (first_rec_q && !held_first_q) begin
							t_q[i] <= $signed(tadj_c[i][32:1]);
							r_q[i] <= ul_q[i];
						end else begin
							t_q[i] <= u_q[i];
							r_q[i] <= u_q[i];
						end
					end
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_DOT_MUL;
				end
				S_DOT_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_DOT_ACC;
				end
				S_DOT_ACC: begin
					acc_q <= acc_q + prod_q;
					if (idx_q == LAST_AXIS) begin
						state_q <= S_DQ;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DOT_MUL;
					end
				end
				S_DQ: begin
					dqneg_q <= acc_q[63];
					dqm_q   <= dot_abs[UNIT_SHIFT +: 32];
					idx_q   <= '0;
					state_q <= S_NUM_MUL;
				end
				S_NUM_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_NUM_GO;
				end
				S_NUM_GO: begin
					numneg_q <= num_c[63];
					if (dqm_q == '0) begin
						if (num_c == '0)
							off_q[idx_q] <= '0;
						else
							off_q[idx_q] <= num_c[63] ? -$signed(off_pos) : $signed(off_pos);
						if (idx_q == LAST_AXIS) begin
							state_q <= S_REC;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_NUM_MUL;
						end
					end else begin
						state_q <= S_NUM_WAIT;
					end
				end
				S_NUM_WAIT: begin
					if (dv_done) begin
						off_q[idx_q] <= (numneg_q ^ dqneg_q) ? -$signed(sat32) : $signed(sat32);
						if (idx_q == LAST_AXIS) begin
							state_q <= S_REC;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_NUM_MUL;
						end
					end
				end
				S_REC: begin
					out_rec_q.vx       <= first_rec_q ? held_q[0] : pt_c[0];
					out_rec_q.vy       <= first_rec_q ? held_q[1] : pt_c[1];
					out_rec_q.vz       <= first_rec_q ? held_q[2] : pt_c[2];
					out_rec_q.ox       <= off_q[0];
					out_rec_q.oy       <= off_q[1];
					out_rec_q.oz       <= off_q[2];
					out_rec_q.path     <= run_len_q;
					out_rec_q.vbase    <= vcount_q;
					out_rec_q.joins    <= first_rec_q ? !held_first_q : 1'b1;
					out_rec_q.run_last <= first_rec_q ? item_q.last == 1'b0 : 1'b1;
					state_q            <= S_OUT;
				end
				S_OUT: begin
					if (!ofull) begin
						vcount_q <= vcount_q + VB_STEP;
						if (item_q.held && first_rec_q) begin
							run_len_q <= run_len_nx;
							ul_q      <= u_q;
							if (item_q.last) begin
								first_rec_q <= 1'b0;
								state_q     <= S_TAN;
							end else begin
								held_q       <= pt_c;
								held_th_q    <= item_q.th;
								held_first_q <= 1'b0;
								state_q      <= S_IDLE;
							end
						end else begin
							run_len_q    <= '0;
							held_first_q <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result queue
	assign ofull = (ocount_q == CNT_W'(QDEPTH));
	assign opush = (state_q == S_OUT) && !ofull;
	assign opop  = pop && (ocount_q != '0);

	always_ff @(posedge clk) begin
		if (opush) ofifo_q[owr_q] <= out_rec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= '0;
			ord_q    <= '0;
			ocount_q <= '0;
		end else begin
			if (opush) owr_q <= owr_q + 1'b1;
			if (opop)  ord_q <= ord_q + 1'b1;
			unique case ({opush, opop})
				2'b10:   ocount_q <= ocount_q + 1'b1;
				2'b01:   ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

	assign empty = (ocount_q == '0);
	assign head  = ofifo_q[ord_q];
endmodule
`default_nettype wire

@@ rtl/pmsb_checker.sv @@
// Port-level checks of polyline_miter_strip_builder and the bind that attaches them.
// Depends on assert_macros.svh and pmsb_pkg.
`default_nettype none
`include "assert_macros.svh"
module pmsb_checker import pmsb_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [31:0] vertex_base,
	input wire logic [31:0] offset_x,
	input wire logic [31:0] path_length,
	input wire logic        joins_previous
);
	logic [31:0] vb_last_q;
	logic        seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			vb_last_q <= '0;
		end else if (pop && !empty) begin
			seen_q    <= 1'b1;
			vb_last_q <= vertex_base;
		end
	end

	`ASSERT_IMPLIES(a_reset_empty, $rose(arst_n), empty, "result queue not empty after reset")
	`ASSERT_NEXT(a_hold_valid, !empty && !pop, !empty, "waiting request dropped")
	`ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(vertex_base) && $stable(offset_x), "waiting request changed")
	`ASSERT_IMPLIES(a_first_len, !empty && !joins_previous, path_length == 32'd0, "line start with nonzero length")
	`ASSERT_IMPLIES(a_base_step, pop && !empty && seen_q, vertex_base == vb_last_q + VB_STEP, "vertex base skipped")
endmodule

bind polyline_miter_strip_builder pmsb_checker u_pmsb_checker (.*);
`default_nettype wire
